// ===== rtl/mm_pkg.sv =====
package mm_pkg;

  // Configuration register port.
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  // Result element: signed Q19.16 dot product, row and column indexes.
  localparam int PROD_W = 35;
  localparam int IDX_W  = 3;

endpackage

// ===== rtl/matrix_multiply.sv =====
// Matrix multiplier, C = A x B, with signed fixed-point elements.
//
// Input channel (in_valid / in_stall): one transaction carries one element,
// tagged by in_matrix_select (0 = A, 1 = B), in row-major order. A is
// row_count by inner_count, B is inner_count by col_count. Elements that
// arrive for a matrix that is already full are dropped. Loading takes one
// cycle per element. The transaction that completes the second matrix starts
// the computation, and in_stall stays high until the whole result is out.
//
// Output channel (out_valid / out_stall): every element of C in row-major
// order, an exact Q19.16 dot product with its row, column and a last flag.
// Each result steps through the shared read, multiply and accumulate
// sequence once per inner element, then is held in the output register.
// A stalled receiver holds the result register and the sequencer waits.
//
// Configuration (cfg_valid / cfg_ready): cfg_ready is high while loading,
// and in_stall is high while cfg_valid is. Any register write abandons a
// partial job. Reset sets all three dimensions to 8 and empties both
// matrices; store contents need no reset.
module matrix_multiply #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_matrix_select,
  input  logic signed [ELEM_WIDTH-1:0]        in_element_value,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mm_pkg::PROD_W-1:0]    out_product_value,
  output logic [mm_pkg::IDX_W-1:0]            out_row,
  output logic [mm_pkg::IDX_W-1:0]            out_col,
  output logic                                out_last_result,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DIMW  = $clog2(MAX_DIM + 1);
  localparam int NW    = 2 * DIMW;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MW    = 2 * ELEM_WIDTH;

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

  function automatic logic [DIMW-1:0] clamp_dim(input logic [mm_pkg::CFG_DATA_W-1:0] v);
    logic [DIMW-1:0] r;
    if (v == '0) begin
      r = DIMW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIMW'(MAX_DIM);
    end else begin
      r = DIMW'(v);
    end
    return r;
  endfunction

  state_t                        state_r;
  logic [mm_pkg::CFG_DATA_W-1:0] row_cfg_r, inner_cfg_r, col_cfg_r;
  logic [CW-1:0]                 left_cnt_r, right_cnt_r;
  logic [CW-1:0]                 left_cnt_nxt, right_cnt_nxt;

  logic [IW-1:0]                 i_r, j_r, k_r;
  logic [AW-1:0]                 a_base_r, a_addr_r, b_addr_r;
  logic signed [ELEM_WIDTH-1:0]  a_q_r, b_q_r;
  logic signed [MW-1:0]          mul_r;
  logic signed [mm_pkg::PROD_W-1:0] acc_r, acc_nxt;

  logic                          out_valid_r;
  logic signed [mm_pkg::PROD_W-1:0] out_value_r;
  logic [mm_pkg::IDX_W-1:0]      out_row_r, out_col_r;
  logic                          out_last_r;

  logic signed [ELEM_WIDTH-1:0]  left_mem  [DEPTH];
  logic signed [ELEM_WIDTH-1:0]  right_mem [DEPTH];

  logic [DIMW-1:0] rows_c, inner_c, cols_c;
  logic [NW-1:0]   left_need, right_need;
  logic            in_accept, cfg_write;
  logic            left_we, right_we, load_done;
  logic            k_last, j_last, i_last;

  assign rows_c  = clamp_dim(row_cfg_r);
  assign inner_c = clamp_dim(inner_cfg_r);
  assign cols_c  = clamp_dim(col_cfg_r);

  assign left_need  = NW'(rows_c) * NW'(inner_c);
  assign right_need = NW'(inner_c) * NW'(cols_c);

  // A pending register write takes priority, so no element is taken with it.
  assign in_stall  = (state_r != S_LOAD) || cfg_valid;
  assign cfg_ready = (state_r == S_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = cfg_valid && cfg_ready;

  // A full matrix simply drops further elements.
  assign left_we  = in_accept && !in_matrix_select && (NW'(left_cnt_r) < left_need);
  assign right_we = in_accept && in_matrix_select && (NW'(right_cnt_r) < right_need);

  assign left_cnt_nxt  = left_cnt_r + CW'(left_we);
  assign right_cnt_nxt = right_cnt_r + CW'(right_we);
  assign load_done = in_accept && (NW'(left_cnt_nxt) >= left_need)
                     && (NW'(right_cnt_nxt) >= right_need);

  assign k_last = (DIMW'(k_r) == inner_c - DIMW'(1));
  assign j_last = (DIMW'(j_r) == cols_c - DIMW'(1));
  assign i_last = (DIMW'(i_r) == rows_c - DIMW'(1));

  assign acc_nxt = acc_r + mm_pkg::PROD_W'(mul_r);

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[AW'(left_cnt_r)] <= in_element_value;
    end
    if (right_we) begin
      right_mem[AW'(right_cnt_r)] <= in_element_value;
    end
    if (state_r == S_READ) begin
      a_q_r <= left_mem[a_addr_r];
      b_q_r <= right_mem[b_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      row_cfg_r   <= mm_pkg::DIM_RESET;
      inner_cfg_r <= mm_pkg::DIM_RESET;
      col_cfg_r   <= mm_pkg::DIM_RESET;
      left_cnt_r  <= '0;
      right_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (cfg_write) begin
            case (cfg_index)
              mm_pkg::REG_ROW_COUNT:   row_cfg_r   <= cfg_data;
              mm_pkg::REG_INNER_COUNT: inner_cfg_r <= cfg_data;
              mm_pkg::REG_COL_COUNT:   col_cfg_r   <= cfg_data;
              default: ;
            endcase
            if (cfg_index == mm_pkg::REG_ROW_COUNT || cfg_index == mm_pkg::REG_INNER_COUNT
                || cfg_index == mm_pkg::REG_COL_COUNT) begin
              left_cnt_r  <= '0;
              right_cnt_r <= '0;
            end
          end else if (load_done) begin
            left_cnt_r  <= '0;
            right_cnt_r <= '0;
            i_r         <= '0;
            j_r         <= '0;
            k_r         <= '0;
            a_base_r    <= '0;
            a_addr_r    <= '0;
            b_addr_r    <= '0;
            acc_r       <= '0;
            state_r     <= S_READ;
          end else begin
            left_cnt_r  <= left_cnt_nxt;
            right_cnt_r <= right_cnt_nxt;
          end
        end
        S_READ: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          mul_r   <= a_q_r * b_q_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (!k_last) begin
            acc_r    <= acc_nxt;
            k_r      <= k_r + IW'(1);
            a_addr_r <= a_addr_r + AW'(1);
            b_addr_r <= b_addr_r + AW'(cols_c);
            state_r  <= S_READ;
          end else begin
            out_value_r <= acc_nxt;
            out_row_r   <= mm_pkg::IDX_W'(i_r);
            out_col_r   <= mm_pkg::IDX_W'(j_r);
            out_last_r  <= i_last && j_last;
            out_valid_r <= 1'b1;
            acc_r       <= '0;
            k_r         <= '0;
            if (j_last) begin
              // Next row of A, first column of B.
              j_r      <= '0;
              i_r      <= i_r + IW'(1);
              a_base_r <= a_base_r + AW'(inner_c);
              a_addr_r <= a_base_r + AW'(inner_c);
              b_addr_r <= '0;
            end else begin
              j_r      <= j_r + IW'(1);
              a_addr_r <= a_base_r;
              b_addr_r <= AW'(j_r) + AW'(1);
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= out_last_r ? S_LOAD : S_READ;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_value_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last_result   = out_last_r;

endmodule
